### rtl/tfpvl_pkg.sv
// ----------------------------------------------------------------------------
// tfpvl_pkg : shared types and constants
// labels, stack depth and the result kind code of the preorder tree builder
// ----------------------------------------------------------------------------
package tfpvl_pkg;

  localparam int LABEL_W       = 7;
  localparam int LABEL_SPACE   = 1 << LABEL_W;
  localparam int DEPTH_W       = 8;
  localparam int MAX_NODES_DEF = 128;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // where the node hangs in the tree
  typedef enum logic [1:0] {
    KIND_ROOT  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

endpackage

### rtl/tree_from_preorder_visited_links.sv
// ----------------------------------------------------------------------------
// tree_from_preorder_visited_links : binary tree from preorder inorder ranks
// places each node of a preorder label stream as root, left or right child
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_label, in_last_of_tree
//  out_     output     out_valid/out_stall out_kind, out_parent, out_last
//
// one label per cycle sustained while out_stall is low; a result moves from the
// input register to the result register when the result register is free or drains
// rst_n is synchronous and clears the visited map, stack top and depth,
// previous label and tree flag; the link memory is not cleared
// out_stall holds the result register; the input register then holds and
// in_stall rises in the same cycle, so nothing is dropped
// an item with in_last_of_tree set clears the tree state once it is placed
//
module tree_from_preorder_visited_links #(
  parameter int MAX_NODES = tfpvl_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tfpvl_pkg::LABEL_W-1:0]    in_label,
  input  logic                             in_last_of_tree,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tfpvl_pkg::kind_t                 out_kind,
  output logic [tfpvl_pkg::LABEL_W-1:0]    out_parent,
  output logic                             out_last
);
  import tfpvl_pkg::*;

  // input register
  logic   s1_valid_r;
  label_t s1_label_r;
  logic   s1_last_r;

  // result register
  logic   out_valid_r;
  kind_t  out_kind_r;
  label_t out_parent_r;
  logic   out_last_r;

  // tree state
  logic [LABEL_SPACE-1:0] seen_r, seen_nxt;
  label_t top_r, top_nxt;
  label_t toplink_r, toplink_nxt;   // link of the current stack top
  label_t below_r;                  // link of toplink_r, read ahead
  depth_t depth_r, depth_nxt;
  label_t prev_r, prev_nxt;
  logic   in_tree_r, in_tree_nxt;

  // stack links, one per label
  label_t link_mem [LABEL_SPACE];

  logic   advance;
  logic   do_pop, do_push, seen_next, next_in_range;
  logic [LABEL_W:0] next_label;
  label_t top_popped;
  depth_t depth_popped;
  kind_t  kind_c;
  label_t parent_c;
  label_t rd_addr;

  // the input register moves on when the result register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  // is label+1 already placed in this tree; the virtual label N never is
  always_comb begin
    next_label    = {1'b0, s1_label_r} + (LABEL_W+1)'(1);
    next_in_range = (32'(next_label) < MAX_NODES) && (s1_label_r != label_t'(LABEL_SPACE - 1));
    seen_next     = next_in_range && seen_r[next_label[LABEL_W-1:0]];
  end

  // placement: root, left child of previous, right child of pop, or empty-stack error
  always_comb begin
    kind_c   = KIND_ROOT;
    parent_c = '0;
    do_pop   = 1'b0;
    if (!in_tree_r) begin
      kind_c = KIND_ROOT;
    end else if (prev_r > s1_label_r) begin
      kind_c   = KIND_LEFT;
      parent_c = prev_r;
    end else if (depth_r == '0) begin
      kind_c = KIND_EMPTY;
    end else begin
      kind_c   = KIND_RIGHT;
      parent_c = top_r;
      do_pop   = 1'b1;
    end
  end

  // stack update: at most one pop then at most one push
  always_comb begin
    top_popped   = do_pop ? toplink_r : top_r;
    depth_popped = do_pop ? depth_r - depth_t'(1) : depth_r;
    do_push      = !seen_next;

    if (do_push) begin
      top_nxt     = s1_label_r;
      toplink_nxt = top_popped;
      depth_nxt   = (depth_popped == '1) ? depth_popped : depth_popped + depth_t'(1);
    end else begin
      top_nxt     = top_popped;
      toplink_nxt = do_pop ? below_r : toplink_r;
      depth_nxt   = depth_popped;
    end

    seen_nxt                 = seen_r;
    seen_nxt[s1_label_r]     = 1'b1;
    prev_nxt                 = s1_label_r;
    in_tree_nxt              = 1'b1;

    // end of tree: links stay, everything else back to reset values
    if (s1_last_r) begin
      seen_nxt    = '0;
      top_nxt     = '0;
      depth_nxt   = '0;
      prev_nxt    = '0;
      in_tree_nxt = 1'b0;
    end
  end

  // read ahead: keep below_r equal to the link of toplink_r
  assign rd_addr = advance ? toplink_nxt : toplink_r;

  always_ff @(posedge clk) begin
    if (advance && do_push) begin
      link_mem[s1_label_r] <= top_popped;
    end
    // a write to the address being read is forwarded
    if (advance && do_push && (s1_label_r == rd_addr)) begin
      below_r <= top_popped;
    end else begin
      below_r <= link_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      top_r       <= '0;
      depth_r     <= '0;
      prev_r      <= '0;
      in_tree_r   <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        seen_r      <= seen_nxt;
        top_r       <= top_nxt;
        depth_r     <= depth_nxt;
        prev_r      <= prev_nxt;
        in_tree_r   <= in_tree_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_label_r <= in_label;
      s1_last_r  <= in_last_of_tree;
    end
    if (advance) begin
      out_kind_r   <= kind_c;
      out_parent_r <= parent_c;
      out_last_r   <= s1_last_r;
      toplink_r    <= toplink_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_parent = out_parent_r;
  assign out_last   = out_last_r;

endmodule

### rtl/tfpvl_checker.sv
// ----------------------------------------------------------------------------
// tfpvl_checker : port checks for the preorder tree builder
// watches the input stall and the result channel over time, bound to the top level
// ----------------------------------------------------------------------------
module tfpvl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input tfpvl_pkg::kind_t              out_kind,
  input logic [tfpvl_pkg::LABEL_W-1:0] out_parent,
  input logic                          out_last
);
  import tfpvl_pkg::*;

  // a held result does not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_parent)
      && $stable(out_last))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // roots and empty-stack errors carry no parent
  a_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ROOT || out_kind == KIND_EMPTY) |-> out_parent == '0)
    else $error("parent set on root or error");

  // the item after an end of tree starts a new tree
  a_new_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> (out_valid |-> out_kind == KIND_ROOT))
    else $error("tree did not restart after last");

  // stall only with an item waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && in_valid |-> out_valid && out_stall)
    else $error("input stalled with result side free");

endmodule

bind tree_from_preorder_visited_links tfpvl_checker u_tfpvl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_kind   (out_kind),
  .out_parent (out_parent),
  .out_last   (out_last)
);
